[sv/amce_pkg.sv]
// ----------------------------------------------------------------------------
// amce_pkg
// Shared widths, codes and default sizes of the access matrix command engine.
// ----------------------------------------------------------------------------
package amce_pkg;

	localparam int KIND_W    = 3;
	localparam int IDX_W     = 4;
	localparam int RIGHT_W   = 3;
	localparam int MASK_W    = 8;
	localparam int COUNT_W   = 5;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 5;

	localparam int DEF_MAX_SUBJECTS = 16;
	localparam int DEF_MAX_OBJECTS  = 16;
	localparam int DEF_NUM_RIGHTS   = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_SUBJECTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_OBJECTS  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD         = 3'd0,
		KIND_CREATE_OBJ   = 3'd1,
		KIND_CREATE_SUBJ  = 3'd2,
		KIND_DESTROY_OBJ  = 3'd3,
		KIND_DESTROY_SUBJ = 3'd4,
		KIND_ENTER        = 3'd5,
		KIND_DELETE       = 3'd6,
		KIND_READ         = 3'd7
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_SKIPPED = 2'd1,
		STATUS_REFUSED = 2'd2,
		STATUS_RANGE   = 2'd3
	} status_t;

endpackage

[sv/amce_ram.sv]
// ----------------------------------------------------------------------------
// amce_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module amce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/amce_ctrl.sv]
// ----------------------------------------------------------------------------
// amce_ctrl
// Command sequencer: guard check, cell read-modify-write, row and column
// walks for create and destroy, and the clearing pass after reset.
// ----------------------------------------------------------------------------
module amce_ctrl #(
	parameter int MAX_SUBJECTS = amce_pkg::DEF_MAX_SUBJECTS,
	parameter int MAX_OBJECTS  = amce_pkg::DEF_MAX_OBJECTS,
	parameter int NUM_RIGHTS   = amce_pkg::DEF_NUM_RIGHTS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	output logic                                        busy,
	input  logic [amce_pkg::KIND_W-1:0]                 kind,
	input  logic [amce_pkg::IDX_W-1:0]                  subject_index,
	input  logic [amce_pkg::IDX_W-1:0]                  object_index,
	input  logic [amce_pkg::RIGHT_W-1:0]                right_index,
	input  logic [amce_pkg::MASK_W-1:0]                 rights_mask,
	input  logic                                        guard_enable,
	input  logic [amce_pkg::RIGHT_W-1:0]                guard_right,
	input  logic [amce_pkg::IDX_W-1:0]                  guard_subject,
	input  logic [amce_pkg::IDX_W-1:0]                  guard_object,
	input  logic                                        cfg_we,
	input  logic [amce_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [amce_pkg::CFG_W-1:0]                  cfg_wdata,
	output logic                                        done,
	output logic                                        executed,
	output logic [amce_pkg::STATUS_W-1:0]               status,
	output logic [amce_pkg::MASK_W-1:0]                 cell_rights,
	output logic [amce_pkg::COUNT_W-1:0]                subject_count,
	output logic [amce_pkg::COUNT_W-1:0]                object_count,
	output logic                                        cur_we,
	output logic [$clog2(MAX_SUBJECTS*MAX_OBJECTS)-1:0] cur_waddr,
	output logic [NUM_RIGHTS-1:0]                       cur_wdata,
	output logic [$clog2(MAX_SUBJECTS*MAX_OBJECTS)-1:0] cur_raddr,
	input  logic [NUM_RIGHTS-1:0]                       cur_rdata,
	output logic                                        tpl_we,
	output logic [$clog2(MAX_SUBJECTS*MAX_OBJECTS)-1:0] tpl_waddr,
	output logic [NUM_RIGHTS-1:0]                       tpl_wdata,
	output logic [$clog2(MAX_SUBJECTS*MAX_OBJECTS)-1:0] tpl_raddr,
	input  logic [NUM_RIGHTS-1:0]                       tpl_rdata
);

	import amce_pkg::*;

	localparam int SW    = $clog2(MAX_SUBJECTS);
	localparam int OW    = $clog2(MAX_OBJECTS);
	localparam int CSW   = $clog2(MAX_SUBJECTS + 1);
	localparam int COW   = $clog2(MAX_OBJECTS + 1);
	localparam int AW    = $clog2(MAX_SUBJECTS * MAX_OBJECTS);
	localparam int CMP_W = 8;

	localparam logic [CSW-1:0] TPL_S_RST = CSW'(MAX_SUBJECTS < 16 ? MAX_SUBJECTS : 16);
	localparam logic [COW-1:0] TPL_O_RST = COW'(MAX_OBJECTS < 16 ? MAX_OBJECTS : 16);
	localparam logic [SW-1:0]  ROW_MAX   = SW'(MAX_SUBJECTS - 1);
	localparam logic [OW-1:0]  COL_MAX   = OW'(MAX_OBJECTS - 1);
	localparam logic [NUM_RIGHTS-1:0] RIGHT_ONE = NUM_RIGHTS'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GUARD,
		S_EXEC,
		S_WALK,
		S_FLUSH
	} fsm_t;

	typedef enum logic [1:0] {
		WM_ZERO,
		WM_SHIFT_COL,
		WM_SHIFT_ROW
	} walk_mode_t;

	fsm_t                    state_q;
	kind_t                   kind_q;
	logic [IDX_W-1:0]        s_q, o_q, gs_q, go_q;
	logic [RIGHT_W-1:0]      r_q, gr_q;
	logic [MASK_W-1:0]       mask_q;
	logic                    gen_q;
	logic [CSW-1:0]          tpl_s_q, live_s_q;
	logic [COW-1:0]          tpl_o_q, live_o_q;
	status_t                 guard_stat_q;
	logic                    guard_pass_q;
	logic [SW-1:0]           row_q, row_last_q;
	logic [OW-1:0]           col_q, col_first_q, col_last_q;
	walk_mode_t              walk_mode_q;
	logic                    clear_q;
	logic                    wr_v_s1;
	logic [AW-1:0]           waddr_s1;
	logic                    zero_s1;
	logic                    done_q, executed_q;
	status_t                 status_q;
	logic [MASK_W-1:0]       cell_q;

	logic                    in_live_cell, right_ok, cell_kind;
	logic                    g_live, g_right_ok;
	logic [NUM_RIGHTS-1:0]   g_sh, bitm;
	logic [AW-1:0]           cell_addr;
	logic                    walk_zero, walk_last;
	logic [SW-1:0]           src_row;
	logic [OW-1:0]           src_col;

	logic                    ex_exec, ex_cur_we, ex_tpl_we, ex_walk;
	status_t                 ex_status;
	logic [NUM_RIGHTS-1:0]   ex_cell_val;
	logic [MASK_W-1:0]       ex_cell_out;
	walk_mode_t              ex_mode;
	logic [SW-1:0]           ex_row_first, ex_row_last;
	logic [OW-1:0]           ex_col_first, ex_col_last;

	function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] row,
			input logic [OW-1:0] col);
		return AW'(AW'(row) * AW'(MAX_OBJECTS) + AW'(col));
	endfunction

	assign in_live_cell = (CMP_W'(s_q) < CMP_W'(live_s_q)) && (CMP_W'(o_q) < CMP_W'(live_o_q));
	assign right_ok     = CMP_W'(r_q) < CMP_W'(NUM_RIGHTS);
	assign g_live       = (CMP_W'(gs_q) < CMP_W'(live_s_q)) && (CMP_W'(go_q) < CMP_W'(live_o_q));
	assign g_right_ok   = CMP_W'(gr_q) < CMP_W'(NUM_RIGHTS);
	assign g_sh         = cur_rdata >> gr_q;
	assign bitm         = RIGHT_ONE << r_q;
	assign cell_addr    = addr_of(SW'(s_q), OW'(o_q));
	assign cell_kind    = (kind_q == KIND_LOAD) || (kind_q == KIND_ENTER) ||
	                      (kind_q == KIND_DELETE) || (kind_q == KIND_READ);

	// walk source and end of walk
	assign src_row   = (walk_mode_q == WM_SHIFT_ROW) ? SW'(row_q + 1'b1) : row_q;
	assign src_col   = (walk_mode_q == WM_SHIFT_COL) ? OW'(col_q + 1'b1) : col_q;
	assign walk_zero = (walk_mode_q == WM_ZERO) ||
	                   ((walk_mode_q == WM_SHIFT_COL) && (col_q == col_last_q)) ||
	                   ((walk_mode_q == WM_SHIFT_ROW) && (row_q == row_last_q));
	assign walk_last = (row_q == row_last_q) && (col_q == col_last_q);

	// command decision on the cell read
	always_comb begin
		ex_exec      = 1'b0;
		ex_status    = guard_stat_q;
		ex_cur_we    = 1'b0;
		ex_tpl_we    = 1'b0;
		ex_walk      = 1'b0;
		ex_cell_val  = cur_rdata;
		ex_mode      = WM_ZERO;
		ex_row_first = '0;
		ex_row_last  = ROW_MAX;
		ex_col_first = '0;
		ex_col_last  = COL_MAX;
		if (guard_pass_q) begin
			ex_status = STATUS_DONE;
			unique case (kind_q)
				KIND_LOAD: begin
					if ((CMP_W'(s_q) < CMP_W'(tpl_s_q)) && (CMP_W'(o_q) < CMP_W'(tpl_o_q))) begin
						ex_cell_val = NUM_RIGHTS'(mask_q);
						ex_cur_we   = 1'b1;
						ex_tpl_we   = 1'b1;
						ex_exec     = 1'b1;
					end else begin
						ex_status = STATUS_RANGE;
					end
				end
				KIND_CREATE_OBJ: begin
					if (CMP_W'(live_o_q) < CMP_W'(tpl_o_q)) begin
						ex_walk      = 1'b1;
						ex_col_first = OW'(live_o_q);
						ex_col_last  = OW'(live_o_q);
					end else begin
						ex_status = STATUS_REFUSED;
					end
				end
				KIND_CREATE_SUBJ: begin
					if (CMP_W'(live_s_q) < CMP_W'(tpl_s_q)) begin
						ex_walk      = 1'b1;
						ex_row_first = SW'(live_s_q);
						ex_row_last  = SW'(live_s_q);
					end else begin
						ex_status = STATUS_REFUSED;
					end
				end
				KIND_DESTROY_OBJ: begin
					if (CMP_W'(o_q) < CMP_W'(live_o_q)) begin
						ex_walk      = 1'b1;
						ex_mode      = WM_SHIFT_COL;
						ex_col_first = OW'(o_q);
						ex_col_last  = OW'(live_o_q - 1'b1);
					end else begin
						ex_status = STATUS_RANGE;
					end
				end
				KIND_DESTROY_SUBJ: begin
					if (CMP_W'(s_q) < CMP_W'(live_s_q)) begin
						ex_walk      = 1'b1;
						ex_mode      = WM_SHIFT_ROW;
						ex_row_first = SW'(s_q);
						ex_row_last  = SW'(live_s_q - 1'b1);
					end else begin
						ex_status = STATUS_RANGE;
					end
				end
				KIND_ENTER: begin
					if (!in_live_cell || !right_ok) begin
						ex_status = STATUS_RANGE;
					end else if (|(tpl_rdata & bitm)) begin
						ex_cell_val = cur_rdata | bitm;
						ex_cur_we   = 1'b1;
						ex_exec     = 1'b1;
					end else begin
						ex_status = STATUS_REFUSED;
					end
				end
				KIND_DELETE: begin
					if (!in_live_cell || !right_ok) begin
						ex_status = STATUS_RANGE;
					end else if (|(cur_rdata & bitm)) begin
						ex_cell_val = cur_rdata & ~bitm;
						ex_cur_we   = 1'b1;
						ex_exec     = 1'b1;
					end else begin
						ex_status = STATUS_REFUSED;
					end
				end
				KIND_READ: begin
					if (in_live_cell) begin
						ex_exec = 1'b1;
					end else begin
						ex_status = STATUS_RANGE;
					end
				end
			endcase
		end
		ex_cell_out = (cell_kind && in_live_cell) ? MASK_W'(ex_cell_val) : '0;
	end

	// memory ports
	always_comb begin
		unique case (state_q)
			S_IDLE:  cur_raddr = addr_of(SW'(guard_subject), OW'(guard_object));
			S_WALK:  cur_raddr = addr_of(src_row, src_col);
			default: cur_raddr = cell_addr;
		endcase
		tpl_raddr = cell_addr;
		if (wr_v_s1) begin
			cur_we    = 1'b1;
			cur_waddr = waddr_s1;
			cur_wdata = zero_s1 ? '0 : cur_rdata;
			tpl_we    = clear_q;
			tpl_waddr = waddr_s1;
			tpl_wdata = '0;
		end else begin
			cur_we    = (state_q == S_EXEC) && ex_cur_we;
			cur_waddr = cell_addr;
			cur_wdata = ex_cell_val;
			tpl_we    = (state_q == S_EXEC) && ex_tpl_we;
			tpl_waddr = cell_addr;
			tpl_wdata = ex_cell_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_WALK;
			kind_q       <= KIND_LOAD;
			s_q          <= '0;
			o_q          <= '0;
			r_q          <= '0;
			mask_q       <= '0;
			gen_q        <= 1'b0;
			gr_q         <= '0;
			gs_q         <= '0;
			go_q         <= '0;
			tpl_s_q      <= TPL_S_RST;
			tpl_o_q      <= TPL_O_RST;
			live_s_q     <= TPL_S_RST;
			live_o_q     <= TPL_O_RST;
			guard_stat_q <= STATUS_DONE;
			guard_pass_q <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			row_last_q   <= ROW_MAX;
			col_first_q  <= '0;
			col_last_q   <= COL_MAX;
			walk_mode_q  <= WM_ZERO;
			clear_q      <= 1'b1;
			wr_v_s1      <= 1'b0;
			waddr_s1     <= '0;
			zero_s1      <= 1'b0;
			done_q       <= 1'b0;
			executed_q   <= 1'b0;
			status_q     <= STATUS_DONE;
			cell_q       <= '0;
		end else begin
			done_q  <= 1'b0;
			wr_v_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q  <= kind_t'(kind);
						s_q     <= subject_index;
						o_q     <= object_index;
						r_q     <= right_index;
						mask_q  <= rights_mask;
						gen_q   <= guard_enable;
						gr_q    <= guard_right;
						gs_q    <= guard_subject;
						go_q    <= guard_object;
						state_q <= S_GUARD;
					end
				end
				S_GUARD: begin
					if (gen_q && !(g_live && g_right_ok)) begin
						guard_stat_q <= STATUS_RANGE;
						guard_pass_q <= 1'b0;
					end else if (gen_q && !g_sh[0]) begin
						guard_stat_q <= STATUS_SKIPPED;
						guard_pass_q <= 1'b0;
					end else begin
						guard_stat_q <= STATUS_DONE;
						guard_pass_q <= 1'b1;
					end
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (ex_walk) begin
						row_q       <= ex_row_first;
						row_last_q  <= ex_row_last;
						col_q       <= ex_col_first;
						col_first_q <= ex_col_first;
						col_last_q  <= ex_col_last;
						walk_mode_q <= ex_mode;
						clear_q     <= 1'b0;
						state_q     <= S_WALK;
					end else begin
						done_q     <= 1'b1;
						executed_q <= ex_exec;
						status_q   <= ex_status;
						cell_q     <= ex_cell_out;
						state_q    <= S_IDLE;
					end
				end
				S_WALK: begin
					wr_v_s1  <= 1'b1;
					waddr_s1 <= addr_of(row_q, col_q);
					zero_s1  <= walk_zero;
					if (walk_last) begin
						state_q <= S_FLUSH;
					end else if (col_q == col_last_q) begin
						col_q <= col_first_q;
						row_q <= SW'(row_q + 1'b1);
					end else begin
						col_q <= OW'(col_q + 1'b1);
					end
				end
				S_FLUSH: begin
					if (!clear_q) begin
						unique case (kind_q)
							KIND_CREATE_OBJ:   live_o_q <= COW'(live_o_q + 1'b1);
							KIND_CREATE_SUBJ:  live_s_q <= CSW'(live_s_q + 1'b1);
							KIND_DESTROY_OBJ:  live_o_q <= COW'(live_o_q - 1'b1);
							KIND_DESTROY_SUBJ: live_s_q <= CSW'(live_s_q - 1'b1);
							default: ;
						endcase
						done_q     <= 1'b1;
						executed_q <= 1'b1;
						status_q   <= STATUS_DONE;
						cell_q     <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				if (cfg_index == CFG_TEMPLATE_SUBJECTS) begin
					tpl_s_q  <= (CMP_W'(cfg_wdata) > CMP_W'(MAX_SUBJECTS)) ?
					            CSW'(MAX_SUBJECTS) : CSW'(cfg_wdata);
					live_s_q <= (CMP_W'(cfg_wdata) > CMP_W'(MAX_SUBJECTS)) ?
					            CSW'(MAX_SUBJECTS) : CSW'(cfg_wdata);
				end else begin
					tpl_o_q  <= (CMP_W'(cfg_wdata) > CMP_W'(MAX_OBJECTS)) ?
					            COW'(MAX_OBJECTS) : COW'(cfg_wdata);
					live_o_q <= (CMP_W'(cfg_wdata) > CMP_W'(MAX_OBJECTS)) ?
					            COW'(MAX_OBJECTS) : COW'(cfg_wdata);
				end
			end
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign executed      = executed_q;
	assign status        = status_q;
	assign cell_rights   = cell_q;
	assign subject_count = COUNT_W'(live_s_q);
	assign object_count  = COUNT_W'(live_o_q);

endmodule

[sv/access_matrix_command_engine_top.sv]
// ----------------------------------------------------------------------------
// access_matrix_command_engine_top
// Subject-by-object access matrix with template, guarded commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result
// appears on the result ports for a single cycle with done high and cannot
// be held off. Load, enter, delete, read and every skipped or refused command
// pass through guard cell read, addressed cell read and result, and a new
// command is taken only once that result appears. Create and destroy walk the
// affected cells through the single read port of the current matrix, one cell
// a cycle: MAX_SUBJECTS cells for a new column, MAX_OBJECTS for a new row,
// MAX_SUBJECTS times (live columns - index) to destroy a column and
// MAX_OBJECTS times (live rows - index) to destroy a row. After reset busy
// stays high while both matrices are cleared; configuration writes are taken
// at any time.
// ----------------------------------------------------------------------------
module access_matrix_command_engine_top #(
	parameter int MAX_SUBJECTS = amce_pkg::DEF_MAX_SUBJECTS,
	parameter int MAX_OBJECTS  = amce_pkg::DEF_MAX_OBJECTS,
	parameter int NUM_RIGHTS   = amce_pkg::DEF_NUM_RIGHTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [amce_pkg::KIND_W-1:0]    kind,
	input  logic [amce_pkg::IDX_W-1:0]     subject_index,
	input  logic [amce_pkg::IDX_W-1:0]     object_index,
	input  logic [amce_pkg::RIGHT_W-1:0]   right_index,
	input  logic [amce_pkg::MASK_W-1:0]    rights_mask,
	input  logic                           guard_enable,
	input  logic [amce_pkg::RIGHT_W-1:0]   guard_right,
	input  logic [amce_pkg::IDX_W-1:0]     guard_subject,
	input  logic [amce_pkg::IDX_W-1:0]     guard_object,
	input  logic                           cfg_we,
	input  logic [amce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [amce_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                           done,
	output logic                           executed,
	output logic [amce_pkg::STATUS_W-1:0]  status,
	output logic [amce_pkg::MASK_W-1:0]    cell_rights,
	output logic [amce_pkg::COUNT_W-1:0]   subject_count,
	output logic [amce_pkg::COUNT_W-1:0]   object_count
);

	import amce_pkg::*;

	localparam int DEPTH = MAX_SUBJECTS * MAX_OBJECTS;
	localparam int AW    = $clog2(DEPTH);

	logic                  cur_we, tpl_we;
	logic [AW-1:0]         cur_waddr, cur_raddr, tpl_waddr, tpl_raddr;
	logic [NUM_RIGHTS-1:0] cur_wdata, cur_rdata, tpl_wdata, tpl_rdata;

	amce_ram #(
		.WIDTH (NUM_RIGHTS),
		.DEPTH (DEPTH)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	amce_ram #(
		.WIDTH (NUM_RIGHTS),
		.DEPTH (DEPTH)
	) u_tpl_ram (
		.clk   (clk),
		.we    (tpl_we),
		.waddr (tpl_waddr),
		.wdata (tpl_wdata),
		.raddr (tpl_raddr),
		.rdata (tpl_rdata)
	);

	amce_ctrl #(
		.MAX_SUBJECTS (MAX_SUBJECTS),
		.MAX_OBJECTS  (MAX_OBJECTS),
		.NUM_RIGHTS   (NUM_RIGHTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.subject_index (subject_index),
		.object_index  (object_index),
		.right_index   (right_index),
		.rights_mask   (rights_mask),
		.guard_enable  (guard_enable),
		.guard_right   (guard_right),
		.guard_subject (guard_subject),
		.guard_object  (guard_object),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.executed      (executed),
		.status        (status),
		.cell_rights   (cell_rights),
		.subject_count (subject_count),
		.object_count  (object_count),
		.cur_we        (cur_we),
		.cur_waddr     (cur_waddr),
		.cur_wdata     (cur_wdata),
		.cur_raddr     (cur_raddr),
		.cur_rdata     (cur_rdata),
		.tpl_we        (tpl_we),
		.tpl_waddr     (tpl_waddr),
		.tpl_wdata     (tpl_wdata),
		.tpl_raddr     (tpl_raddr),
		.tpl_rdata     (tpl_rdata)
	);

endmodule
